// ===== src/ocd_pkg.sv =====
// shared widths, coefficient tables and types for the oklab color difference core
package ocd_pkg;

    localparam int IN_W          = 21;
    localparam int DIST_W        = 20;
    localparam int FRACTION_DEF  = 16;
    localparam int COEF_W        = 32;
    localparam int COEF_FRAC     = 29;
    localparam int LMS_DROP      = 18;
    localparam int LMS_W         = IN_W + COEF_FRAC - LMS_DROP;
    localparam int DIST_DROP     = 4;

    typedef logic signed [IN_W-1:0]   t_chan;
    typedef logic signed [COEF_W-1:0] t_coef;

    // decimal coefficients rounded half up at 2^-29
    localparam logic [63:0] C_SCALE = 64'd536870912;
    localparam logic [63:0] C_HALF  = 64'd5000000000;
    localparam logic [63:0] C_DEN   = 64'd10000000000;

    localparam t_coef LMS_COEF [9] = '{
        t_coef'((64'd4122214708 * C_SCALE + C_HALF) / C_DEN),
        t_coef'((64'd5363325363 * C_SCALE + C_HALF) / C_DEN),
        t_coef'((64'd514459929 * C_SCALE + C_HALF) / C_DEN),
        t_coef'((64'd2119034982 * C_SCALE + C_HALF) / C_DEN),
        t_coef'((64'd6806995451 * C_SCALE + C_HALF) / C_DEN),
        t_coef'((64'd1073969566 * C_SCALE + C_HALF) / C_DEN),
        t_coef'((64'd883024619 * C_SCALE + C_HALF) / C_DEN),
        t_coef'((64'd2817188376 * C_SCALE + C_HALF) / C_DEN),
        t_coef'((64'd6299787005 * C_SCALE + C_HALF) / C_DEN)
    };

    localparam t_coef LAB_COEF [9] = '{
        t_coef'((64'd2104542553 * C_SCALE + C_HALF) / C_DEN),
        t_coef'((64'd7936177850 * C_SCALE + C_HALF) / C_DEN),
        -t_coef'((64'd40720468 * C_SCALE + C_HALF) / C_DEN),
        t_coef'((64'd19779984951 * C_SCALE + C_HALF) / C_DEN),
        -t_coef'((64'd24285922050 * C_SCALE + C_HALF) / C_DEN),
        t_coef'((64'd4505937099 * C_SCALE + C_HALF) / C_DEN),
        t_coef'((64'd259040371 * C_SCALE + C_HALF) / C_DEN),
        t_coef'((64'd7827717662 * C_SCALE + C_HALF) / C_DEN),
        -t_coef'((64'd8086757660 * C_SCALE + C_HALF) / C_DEN)
    };

endpackage

// ===== src/ocd_cbrt_cell.sv =====
// one digit cell of the pipelined cube root: one root bit per cell
module ocd_cbrt_cell #(
    parameter int N_W   = 60,
    parameter int R_W   = 20,
    parameter int SHIFT = 0
) (
    input  logic             i_clk,
    input  logic [N_W-1:0]   i_rem,
    input  logic [R_W-1:0]   i_root,
    input  logic [2*R_W-1:0] i_sq,
    output logic [N_W-1:0]   o_rem,
    output logic [R_W-1:0]   o_root,
    output logic [2*R_W-1:0] o_sq
);

    localparam int SQ_W  = 2 * R_W;
    localparam int B_W   = 2 * R_W + 2;
    localparam int CMP_W = (N_W > B_W) ? N_W : B_W;

    logic [N_W-1:0]  r_rem,  n_rem;
    logic [R_W-1:0]  r_root, n_root;
    logic [SQ_W-1:0] r_sq,   n_sq;
    logic [R_W-1:0]  y2;
    logic [SQ_W-1:0] sq2;
    logic [B_W-1:0]  base;
    logic [B_W-1:0]  b;
    logic            take;

    always_comb begin
        y2   = {i_root[R_W-2:0], 1'b0};
        sq2  = {i_sq[SQ_W-3:0], 2'b00};
        // b = 3*y*(y+1)+1 from the running square, no multiplier
        base = B_W'(sq2) + B_W'(y2);
        b    = base + {base[B_W-2:0], 1'b0} + B_W'(1);
        take = CMP_W'(i_rem >> SHIFT) >= CMP_W'(b);
        if (take) begin
            n_rem  = i_rem - (N_W'(b) << SHIFT);
            n_root = y2 | R_W'(1);
            n_sq   = sq2 + SQ_W'({y2, 1'b0}) + SQ_W'(1);
        end else begin
            n_rem  = i_rem;
            n_root = y2;
            n_sq   = sq2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_root <= n_root;
        r_sq   <= n_sq;
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_sq   = r_sq;

endmodule

// ===== src/ocd_sqrt_cell.sv =====
// one digit cell of the pipelined square root: one result bit per cell
module ocd_sqrt_cell #(
    parameter int W       = 58,
    parameter int BIT_POS = 0
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_rem,
    input  logic [W-1:0] i_y,
    output logic [W-1:0] o_rem,
    output logic [W-1:0] o_y
);

    localparam logic [W-1:0] BIT = W'(1) << (2 * BIT_POS);

    logic [W-1:0] r_rem, n_rem;
    logic [W-1:0] r_y,   n_y;
    logic [W:0]   trial;
    logic         take;

    always_comb begin
        trial = {1'b0, i_y} + {1'b0, BIT};
        take  = {1'b0, i_rem} >= trial;
        if (take) begin
            n_rem = i_rem - trial[W-1:0];
            n_y   = (i_y >> 1) + BIT;
        end else begin
            n_rem = i_rem;
            n_y   = i_y >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_y   <= n_y;
    end

    assign o_rem = r_rem;
    assign o_y   = r_y;

endmodule

// ===== src/oklab_color_difference_core.sv =====
// oklab distance between two linear rgb colors, fully pipelined
// throughput: one word per cycle; busy is always low
// the cube root and square root chains make up most of the latency, one result bit per cell
// reset clears only the valid line; no result leaves until a started word arrives
// the receiver cannot stall: o_strobe marks each result for exactly one cycle
module oklab_color_difference_core #(
    parameter int FRACTION_BITS = ocd_pkg::FRACTION_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [ocd_pkg::IN_W-1:0] i_left_red,
    input  logic signed [ocd_pkg::IN_W-1:0] i_left_green,
    input  logic signed [ocd_pkg::IN_W-1:0] i_left_blue,
    input  logic signed [ocd_pkg::IN_W-1:0] i_right_red,
    input  logic signed [ocd_pkg::IN_W-1:0] i_right_green,
    input  logic signed [ocd_pkg::IN_W-1:0] i_right_blue,
    output logic [ocd_pkg::DIST_W-1:0]    o_distance,
    output logic                          o_strobe
);

    localparam int IN_W      = ocd_pkg::IN_W;
    localparam int COEF_W    = ocd_pkg::COEF_W;
    localparam int LMS_W     = ocd_pkg::LMS_W;
    localparam int LMS_DROP  = ocd_pkg::LMS_DROP;
    localparam int CBRT_PAD  = 29 - ((FRACTION_BITS + 40) % 3);
    localparam int ROOT_BITS = (FRACTION_BITS + 11 + CBRT_PAD) / 3;
    localparam int DIFF_DROP = ROOT_BITS + 25 - FRACTION_BITS;
    localparam int N_W       = LMS_W + CBRT_PAD;
    localparam int CR_CELLS  = (N_W + 2) / 3;
    localparam int ROOT_W    = CR_CELLS;
    localparam int NP_W      = 3 * CR_CELLS;
    localparam int LP_W      = IN_W + COEF_W;
    localparam int LA_W      = LP_W + 2;
    localparam int RD_W      = ROOT_W + 1;
    localparam int BP_W      = RD_W + COEF_W;
    localparam int LAB_W     = BP_W + 2;
    localparam int MAG_W     = LAB_W + 1 - DIFF_DROP;
    localparam int SUM_W     = 2 * MAG_W + 2;
    localparam int SQ_CELLS  = SUM_W / 2;
    localparam int RND_W     = SQ_CELLS + 1;
    localparam int DQ_W      = RND_W - ocd_pkg::DIST_DROP;
    localparam int LAT       = 11 + CR_CELLS + SQ_CELLS;

    logic accept;
    logic [LAT-1:0] r_vld, n_vld;

    assign busy   = 1'b0;
    assign accept = start;

    always_comb begin
        n_vld = {r_vld[LAT-2:0], accept};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // input word, lanes 0..2 left color, 3..5 right color
    ocd_pkg::t_chan r_rgb [6];

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rgb[0] <= i_left_red;
            r_rgb[1] <= i_left_green;
            r_rgb[2] <= i_left_blue;
            r_rgb[3] <= i_right_red;
            r_rgb[4] <= i_right_green;
            r_rgb[5] <= i_right_blue;
        end
    end

    // rgb to lms products, sums, clamp and rounding
    logic signed [LP_W-1:0] r_lprod [6][3];
    logic signed [LA_W-1:0] r_lacc  [6];
    logic [LMS_W-1:0]       r_lms   [6];

    for (genvar c = 0; c < 6; c++) begin : g_lms
        localparam int CB = (c / 3) * 3;
        localparam int RW = c % 3;
        logic [LA_W-1:0] pos;
        logic [LA_W-1:0] rnd;
        for (genvar j = 0; j < 3; j++) begin : g_prod
            always_ff @(posedge i_clk) begin
                r_lprod[c][j] <= $signed(ocd_pkg::LMS_COEF[RW*3 + j]) * $signed(r_rgb[CB + j]);
            end
        end
        always_comb begin
            pos = r_lacc[c][LA_W-1] ? '0 : r_lacc[c];
            rnd = pos + (LA_W'(1) << (LMS_DROP - 1));
        end
        always_ff @(posedge i_clk) begin
            r_lacc[c] <= LA_W'(r_lprod[c][0]) + LA_W'(r_lprod[c][1])
                       + LA_W'(r_lprod[c][2]);
            r_lms[c]  <= rnd[LMS_DROP +: LMS_W];
        end
    end

    // cube root chains, one per lms channel
    logic [NP_W-1:0]     cr_rem  [6][CR_CELLS+1];
    logic [ROOT_W-1:0]   cr_root [6][CR_CELLS+1];
    logic [2*ROOT_W-1:0] cr_sq   [6][CR_CELLS+1];

    for (genvar c = 0; c < 6; c++) begin : g_cbrt
        assign cr_rem[c][0]  = NP_W'({r_lms[c], {CBRT_PAD{1'b0}}});
        assign cr_root[c][0] = '0;
        assign cr_sq[c][0]   = '0;
        for (genvar k = 0; k < CR_CELLS; k++) begin : g_cell
            ocd_cbrt_cell #(
                .N_W   (NP_W),
                .R_W   (ROOT_W),
                .SHIFT (3 * (CR_CELLS - 1 - k))
            ) u_cell (
                .i_clk  (i_clk),
                .i_rem  (cr_rem[c][k]),
                .i_root (cr_root[c][k]),
                .i_sq   (cr_sq[c][k]),
                .o_rem  (cr_rem[c][k+1]),
                .o_root (cr_root[c][k+1]),
                .o_sq   (cr_sq[c][k+1])
            );
        end
    end

    // the lab matrix is linear, so the difference goes through it once
    logic signed [RD_W-1:0]  r_rdiff [3];
    logic signed [BP_W-1:0]  r_bprod [3][3];
    logic signed [LAB_W-1:0] r_lab   [3];
    logic [MAG_W-1:0]        r_mag   [3];
    logic [2*MAG_W-1:0]      r_msq   [3];
    logic [SUM_W-1:0]        r_sum;

    for (genvar i = 0; i < 3; i++) begin : g_lab
        logic [LAB_W-1:0] absv;
        logic [LAB_W:0]   rnd;
        always_comb begin
            absv = r_lab[i][LAB_W-1] ? LAB_W'(-r_lab[i]) : LAB_W'(r_lab[i]);
            rnd  = {1'b0, absv} + ((LAB_W+1)'(1) << (DIFF_DROP - 1));
        end
        for (genvar j = 0; j < 3; j++) begin : g_prod
            always_ff @(posedge i_clk) begin
                r_bprod[i][j] <= $signed(ocd_pkg::LAB_COEF[i*3 + j]) * r_rdiff[j];
            end
        end
        always_ff @(posedge i_clk) begin
            r_rdiff[i] <= $signed({1'b0, cr_root[i][CR_CELLS]})
                        - $signed({1'b0, cr_root[i+3][CR_CELLS]});
            r_lab[i]   <= LAB_W'(r_bprod[i][0]) + LAB_W'(r_bprod[i][1])
                        + LAB_W'(r_bprod[i][2]);
            r_mag[i]   <= rnd[DIFF_DROP +: MAG_W];
            r_msq[i]   <= r_mag[i] * r_mag[i];
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= SUM_W'(r_msq[0]) + SUM_W'(r_msq[1]) + SUM_W'(r_msq[2]);
    end

    // square root chain
    logic [SUM_W-1:0] sq_rem [SQ_CELLS+1];
    logic [SUM_W-1:0] sq_y   [SQ_CELLS+1];

    assign sq_rem[0] = r_sum;
    assign sq_y[0]   = '0;

    for (genvar k = 0; k < SQ_CELLS; k++) begin : g_sqrt
        ocd_sqrt_cell #(
            .W       (SUM_W),
            .BIT_POS (SQ_CELLS - 1 - k)
        ) u_cell (
            .i_clk (i_clk),
            .i_rem (sq_rem[k]),
            .i_y   (sq_y[k]),
            .o_rem (sq_rem[k+1]),
            .o_y   (sq_y[k+1])
        );
    end

    // round off the four guard bits and saturate
    logic [RND_W-1:0]              dist_rnd;
    logic [DQ_W-1:0]               dist_q;
    logic [ocd_pkg::DIST_W-1:0]    r_dist, n_dist;

    always_comb begin
        dist_rnd = RND_W'(sq_y[SQ_CELLS][SQ_CELLS-1:0])
                 + (RND_W'(1) << (ocd_pkg::DIST_DROP - 1));
        dist_q   = dist_rnd[ocd_pkg::DIST_DROP +: DQ_W];
        if (dist_q > DQ_W'({ocd_pkg::DIST_W{1'b1}})) begin
            n_dist = '1;
        end else begin
            n_dist = dist_q[ocd_pkg::DIST_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_dist <= n_dist;
    end

    assign o_distance = r_dist;
    assign o_strobe   = r_vld[LAT-1];

endmodule
